// ===== src/assert_macros.svh =====
// assertion macros used by the rtl
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset only
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset only
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sha1md_pkg.sv =====
// shared types, constants and round functions of the sha-1 digest unit
// no dependencies
package sha1md_pkg;

    localparam int WORD_W    = 32;
    localparam int NUM_H     = 5;
    localparam int BLK_WORDS = 16;
    localparam int CNT_W     = 61;

    typedef logic [WORD_W-1:0] t_word;

    // standard initial chaining values
    localparam t_word H_INIT [NUM_H] = '{
        32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
    };

    localparam t_word K_0 = 32'h5A82_7999;
    localparam t_word K_1 = 32'h6ED9_EBA1;
    localparam t_word K_2 = 32'h8F1B_BCDC;
    localparam t_word K_3 = 32'hCA62_C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [2:0] LAST_HWORD = 3'd4;
    localparam logic [2:0] HSEQ_END   = 3'd5;
    localparam logic [5:0] LEN_POS    = 6'd56;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_HLOAD,
        S_ROUND,
        S_HSTORE,
        S_ORD,
        S_OWR
    } t_state;

    function automatic t_word f_round_k(input logic [6:0] t);
        t_word k;
        if (t < 7'd20) begin
            k = K_0;
        end else if (t < 7'd40) begin
            k = K_1;
        end else if (t < 7'd60) begin
            k = K_2;
        end else begin
            k = K_3;
        end
        return k;
    endfunction

    function automatic t_word f_round_f(input logic [6:0] t, input t_word b,
                                        input t_word c, input t_word d);
        t_word f;
        if (t < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (t < 7'd40) begin
            f = b ^ c ^ d;
        end else if (t < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

// ===== src/sha1md_intf.sv =====
// valid/ready channel interfaces of the sha-1 digest unit
// depends on sha1md_pkg
interface sha1md_msg_if import sha1md_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1md_dig_if import sha1md_pkg::*; ();
    logic       valid;
    logic       ready;
    t_word      digest_word;
    logic [2:0] word_number;
    logic       last_word;

    modport source (output valid, digest_word, word_number, last_word, input ready);
    modport sink   (input valid, digest_word, word_number, last_word, output ready);
endinterface

// ===== src/sha1_message_digest_unit.sv =====
// sha-1 digest unit: byte-wide message in, five digest words out
// depends on sha1md_pkg, sha1md_intf.sv and assert_macros.svh
//
//  channel | dir | payload                                  | transfer when
//  --------+-----+------------------------------------------+------------------
//  i_msg   | in  | data_byte, byte_present, end_of_message  | valid & ready
//  o_dig   | out | digest_word, word_number, last_word      | valid & ready
//
// bytes are taken while idle; every 64th byte adds a compression (read the
// chaining hash, 80 rounds fed by the block memory read port, add back into
// the hash memory), and no byte is taken until it is done
// end of message: padding writes, one or two compressions, then each digest
// word through the hash memory read port
// reset is synchronous; afterwards the hash memory reads as the initial values
// a stalled o_dig holds the word in the output register; i_msg keeps flowing
// into the next message while the last digest word waits
`include "assert_macros.svh"

module sha1_message_digest_unit import sha1md_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha1md_msg_if.sink    i_msg,
    sha1md_dig_if.source  o_dig
);

    // control state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_pad_pending;   // end of message seen, digest owed
    logic               r_in_pad;        // padding has started
    logic               r_final;         // block being compressed carries the length
    logic               r_first;         // next pad write is the 0x80 word
    logic               r_lenhere;       // this pad block gets the length words
    logic [3:0]         r_widx;
    logic [2:0]         r_cnt;
    logic [6:0]         r_rnd;
    logic [NUM_H-1:0]   r_hvalid;
    logic               r_out_valid;

    // payload
    t_word              r_acc;
    t_word              r_a, r_b, r_c, r_d, r_e;
    t_word              r_sched [BLK_WORDS];
    t_word              r_blk_mem [BLK_WORDS];
    t_word              r_blk_rd;
    t_word              r_hash_mem [NUM_H];
    t_word              r_hash_rd;
    t_word              r_out_word;
    logic [2:0]         r_out_num;
    logic               r_out_last;

    logic               in_fire;
    logic               blk_full;
    logic               out_load;
    logic [1:0]         lane;
    logic [5:0]         pos;

    logic               blk_we;
    logic [3:0]         blk_waddr;
    t_word              blk_wdata;
    logic [3:0]         blk_raddr;
    logic               hash_we;
    logic [2:0]         hash_waddr;
    t_word              hash_wdata;
    logic [2:0]         hash_raddr;

    t_word              pad_word;
    t_word              w_cur;
    t_word              w_mix;
    t_word              t_sum;

    assign lane     = r_count[1:0];
    assign pos      = r_count[5:0];
    assign in_fire  = i_msg.valid & i_msg.ready;
    assign blk_full = in_fire & i_msg.byte_present & (pos == 6'd63);
    assign out_load = (r_state == S_OWR) & (~r_out_valid | o_dig.ready);
    assign n_count  = r_count + {{(CNT_W-1){1'b0}}, i_msg.byte_present};

    assign i_msg.ready       = (r_state == S_IDLE);
    assign o_dig.valid       = r_out_valid;
    assign o_dig.digest_word = r_out_word;
    assign o_dig.word_number = r_out_num;
    assign o_dig.last_word   = r_out_last;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (blk_full) begin
                        n_state = S_HLOAD;
                    end else if (i_msg.end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_widx == 4'd15) begin
                    n_state = S_HLOAD;
                end
            end
            S_HLOAD: begin
                if (r_cnt == HSEQ_END) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (r_rnd == LAST_ROUND) begin
                    n_state = S_HSTORE;
                end
            end
            S_HSTORE: begin
                if (r_cnt == HSEQ_END) begin
                    if (r_final) begin
                        n_state = S_ORD;
                    end else if (r_pad_pending) begin
                        n_state = S_PAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ORD: begin
                n_state = S_OWR;
            end
            S_OWR: begin
                if (out_load) begin
                    n_state = (r_cnt == LAST_HWORD) ? S_IDLE : S_ORD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // padding word for the current write slot
    always_comb begin
        pad_word = '0;
        if (r_first) begin
            case (lane)
                2'd0:    pad_word = {PAD_BYTE, 24'h0};
                2'd1:    pad_word = {r_acc[31:24], PAD_BYTE, 16'h0};
                2'd2:    pad_word = {r_acc[31:16], PAD_BYTE, 8'h0};
                default: pad_word = {r_acc[31:8], PAD_BYTE};
            endcase
        end else if (r_lenhere && (r_widx == 4'd14)) begin
            pad_word = r_count[60:29];
        end else if (r_lenhere && (r_widx == 4'd15)) begin
            pad_word = {r_count[28:0], 3'b000};
        end
    end

    // memory port control; block memory writes and reads never share a state,
    // hash memory writes entry k-1 while it reads entry k
    always_comb begin
        blk_we     = 1'b0;
        blk_waddr  = r_widx;
        blk_wdata  = pad_word;
        blk_raddr  = '0;
        hash_we    = 1'b0;
        hash_waddr = r_cnt - 3'd1;
        hash_wdata = r_hash_rd + r_a;
        hash_raddr = '0;
        case (r_state)
            S_IDLE: begin
                blk_we    = in_fire & i_msg.byte_present & (lane == 2'd3);
                blk_waddr = pos[5:2];
                blk_wdata = {r_acc[31:8], i_msg.data_byte};
            end
            S_PAD: begin
                blk_we = 1'b1;
            end
            S_HLOAD: begin
                hash_raddr = (r_cnt < HSEQ_END) ? r_cnt : 3'd0;
            end
            S_ROUND: begin
                blk_raddr = r_rnd[3:0] + 4'd1;
            end
            S_HSTORE: begin
                hash_we    = (r_cnt != 3'd0);
                hash_raddr = (r_cnt < HSEQ_END) ? r_cnt : 3'd0;
            end
            S_ORD, S_OWR: begin
                hash_raddr = r_cnt;
            end
            default: begin
                blk_we = 1'b0;
            end
        endcase
    end

    // one round: schedule word from memory for the first 16, else from the taps
    assign w_mix = r_sched[13] ^ r_sched[8] ^ r_sched[2] ^ r_sched[0];
    assign w_cur = (r_rnd < 7'd16) ? r_blk_rd : {w_mix[30:0], w_mix[31]};
    assign t_sum = {r_a[26:0], r_a[31:27]} + f_round_f(r_rnd, r_b, r_c, r_d)
                 + r_e + w_cur + f_round_k(r_rnd);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_pad_pending <= 1'b0;
            r_in_pad      <= 1'b0;
            r_final       <= 1'b0;
            r_first       <= 1'b0;
            r_lenhere     <= 1'b0;
            r_widx        <= '0;
            r_cnt         <= '0;
            r_rnd         <= '0;
            r_hvalid      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_dig.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt   <= '0;
                    r_final <= 1'b0;
                    if (in_fire) begin
                        r_count       <= n_count;
                        r_pad_pending <= i_msg.end_of_message;
                        if (!blk_full && i_msg.end_of_message) begin
                            r_in_pad  <= 1'b1;
                            r_first   <= 1'b1;
                            r_widx    <= n_count[5:2];
                            r_lenhere <= (n_count[5:0] < LEN_POS);
                        end
                    end
                end
                S_PAD: begin
                    r_widx  <= r_widx + 4'd1;
                    r_first <= 1'b0;
                    if (r_widx == 4'd15) begin
                        r_final <= r_lenhere;
                        r_cnt   <= '0;
                    end
                end
                S_HLOAD: begin
                    r_cnt <= r_cnt + 3'd1;
                    r_rnd <= '0;
                end
                S_ROUND: begin
                    r_rnd <= r_rnd + 7'd1;
                    r_cnt <= '0;
                end
                S_HSTORE: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt != 3'd0) begin
                        r_hvalid[r_cnt - 3'd1] <= 1'b1;
                    end
                    if (r_cnt == HSEQ_END) begin
                        if (r_final) begin
                            r_cnt <= '0;
                        end else if (r_in_pad) begin
                            // length did not fit: one more all-zero block with it
                            r_widx    <= '0;
                            r_first   <= 1'b0;
                            r_lenhere <= 1'b1;
                        end else if (r_pad_pending) begin
                            r_in_pad  <= 1'b1;
                            r_first   <= 1'b1;
                            r_widx    <= r_count[5:2];
                            r_lenhere <= (r_count[5:0] < LEN_POS);
                        end
                    end
                end
                S_OWR: begin
                    if (out_load) begin
                        if (r_cnt == LAST_HWORD) begin
                            // digest done: back to the initial hash for the next message
                            r_hvalid      <= '0;
                            r_count       <= '0;
                            r_pad_pending <= 1'b0;
                            r_in_pad      <= 1'b0;
                            r_final       <= 1'b0;
                        end else begin
                            r_cnt <= r_cnt + 3'd1;
                        end
                    end
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    // memories and datapath
    always_ff @(posedge i_clk) begin
        if (blk_we) begin
            r_blk_mem[blk_waddr] <= blk_wdata;
        end
        r_blk_rd <= r_blk_mem[blk_raddr];

        if (hash_we) begin
            r_hash_mem[hash_waddr] <= hash_wdata;
        end
        // entries not written since reset or the last digest read as initial values
        r_hash_rd <= r_hvalid[hash_raddr] ? r_hash_mem[hash_raddr] : H_INIT[hash_raddr];

        case (r_state)
            S_IDLE: begin
                if (in_fire && i_msg.byte_present) begin
                    case (lane)
                        2'd0:    r_acc <= {i_msg.data_byte, 24'h0};
                        2'd1:    r_acc <= {r_acc[31:24], i_msg.data_byte, 16'h0};
                        2'd2:    r_acc <= {r_acc[31:16], i_msg.data_byte, 8'h0};
                        default: r_acc <= {r_acc[31:8], i_msg.data_byte};
                    endcase
                end
            end
            S_HLOAD, S_HSTORE: begin
                if (r_cnt != 3'd0) begin
                    r_a <= r_b;
                    r_b <= r_c;
                    r_c <= r_d;
                    r_d <= r_e;
                    r_e <= r_hash_rd;
                end
            end
            S_ROUND: begin
                r_a <= t_sum;
                r_b <= r_a;
                r_c <= {r_b[1:0], r_b[31:2]};
                r_d <= r_c;
                r_e <= r_d;
                for (int i = 0; i < BLK_WORDS - 1; i++) begin
                    r_sched[i] <= r_sched[i+1];
                end
                r_sched[BLK_WORDS-1] <= w_cur;
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase

        if (out_load) begin
            r_out_word <= r_hash_rd;
            r_out_num  <= r_cnt;
            r_out_last <= (r_cnt == LAST_HWORD);
        end
    end

    `ASSERT_NEXT(a_full_block_compress, in_fire && i_msg.byte_present && (pos == 6'd63), r_state == S_HLOAD, "completed block did not start a compression")
    `ASSERT_SAME(a_round_range, r_state == S_ROUND, r_rnd <= LAST_ROUND, "round counter ran past the last round")
    `ASSERT_SAME(a_last_flag, o_dig.valid, o_dig.last_word == (o_dig.word_number == LAST_HWORD), "last_word does not match word_number")
    `ASSERT_SAME(a_hash_port_apart, hash_we, hash_waddr != hash_raddr, "hash memory read and write hit the same entry")

endmodule

// ===== tb/sha1_message_digest_unit_test.sv =====
// self-checking testbench of the byte-fed sha-1 digest unit: directed table, then random messages
// depends on sha1md_pkg, sha1md_intf.sv and the sha1_message_digest_unit rtl
module sha1_message_digest_unit_test import sha1md_pkg::*; ();

    localparam int STALL_CYCLES  = 400;   // long receiver hold-off
    localparam int WATCHDOG_MAX  = 3000;  // cycles without any transfer
    localparam int SETTLE_CYCLES = 250;   // tail after the last digest word
    localparam int PHASE_ITEMS   = 12;
    localparam int PHASE_MSGS    = 1;

    typedef enum logic [1:0] {
        DIG_PREDICTED,
        DIG_EMPTY,
        DIG_ABC
    } t_known;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
        t_known     known;
    } t_stim_row;

    typedef struct {
        t_word      digest_word;
        logic [2:0] word_number;
        logic       last_word;
    } t_digest_result;

    // digests anyone can look up: empty message and "abc"
    localparam t_word KNOWN_DIGESTS [3][NUM_H] = '{
        '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{32'hDA39A3EE, 32'h5E6B4B0D, 32'h3255BFEF, 32'h95601890, 32'hAFD80709},
        '{32'hA9993E36, 32'h4706816A, 32'hBA3E2571, 32'h7850C26C, 32'h9CD0D89D}
    };

    localparam int N_DIRECTED = 19;
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        '{8'h00, 1'b0, 1'b1, DIG_EMPTY},      // empty message straight after reset
        '{8'h00, 1'b0, 1'b0, DIG_PREDICTED},  // neither flag: ignored
        '{8'hFF, 1'b0, 1'b0, DIG_PREDICTED},  // ignored, data bits high
        '{8'h61, 1'b1, 1'b0, DIG_PREDICTED},  // "abc", last byte on the final item
        '{8'h62, 1'b1, 1'b0, DIG_PREDICTED},
        '{8'h63, 1'b1, 1'b1, DIG_ABC},
        '{8'h61, 1'b1, 1'b0, DIG_PREDICTED},  // "abc" closed by an empty final item
        '{8'h5A, 1'b0, 1'b0, DIG_PREDICTED},
        '{8'h62, 1'b1, 1'b0, DIG_PREDICTED},
        '{8'h63, 1'b1, 1'b0, DIG_PREDICTED},
        '{8'hA5, 1'b0, 1'b1, DIG_ABC},
        '{8'h00, 1'b1, 1'b1, DIG_PREDICTED},  // single zero byte
        '{8'hFF, 1'b1, 1'b1, DIG_PREDICTED},  // single all-ones byte
        '{8'hFF, 1'b1, 1'b0, DIG_PREDICTED},
        '{8'h00, 1'b1, 1'b0, DIG_PREDICTED},
        '{8'hAA, 1'b0, 1'b0, DIG_PREDICTED},
        '{8'h55, 1'b1, 1'b0, DIG_PREDICTED},
        '{8'hC3, 1'b0, 1'b1, DIG_PREDICTED},
        '{8'h00, 1'b0, 1'b1, DIG_EMPTY}       // state is back at reset after a digest
    };

    logic i_clk;
    logic i_rst_n;

    sha1md_msg_if msg_if ();
    sha1md_dig_if dig_if ();

    sha1_message_digest_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_if),
        .o_dig   (dig_if)
    );

    // predictor state
    t_word          chain_h [NUM_H];
    t_word          blk_w [BLK_WORDS];
    logic [CNT_W-1:0] byte_cnt;

    t_digest_result digest_words_due [$];

    int   mismatches    = 0;
    int   items_sent    = 0;
    int   src_idle_pct  = 0;
    int   sink_idle_pct = 0;
    logic hold_req      = 1'b0;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic t_word rol32(input t_word x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void clear_hash_state();
        for (int i = 0; i < NUM_H; i++) chain_h[i] = H_INIT[i];
        for (int i = 0; i < BLK_WORDS; i++) blk_w[i] = '0;
        byte_cnt = '0;
    endfunction

    function automatic void put_block_byte(input int pos, input logic [7:0] v);
        blk_w[pos / 4][(3 - pos % 4) * 8 +: 8] = v;
    endfunction

    // 80-round compression of blk_w into chain_h
    function automatic void fold_block();
        t_word w [80];
        t_word a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) w[i] = blk_w[i];
        for (int i = 16; i < 80; i++) w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rol32(a, 5) + f + e + w[i] + k;
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    // one accepted item; on a final item the five digest words are queued,
    // from the known table when the row names one
    function automatic void absorb_item(input logic [7:0] data, input logic present,
                                        input logic eom, input t_known known);
        logic [63:0]    len_bits;
        int             pos;
        t_digest_result r;
        if (present) begin
            put_block_byte(int'(byte_cnt[5:0]), data);
            byte_cnt = byte_cnt + 1'b1;
            if (byte_cnt[5:0] == 6'd0) fold_block();
        end
        if (!eom) return;
        len_bits = {byte_cnt, 3'b000};
        pos = int'(byte_cnt[5:0]);
        put_block_byte(pos, 8'h80);
        pos++;
        // no room for the length: pad out and fold an extra block
        if (pos > 56) begin
            while (pos < 64) begin
                put_block_byte(pos, 8'h00);
                pos++;
            end
            fold_block();
            pos = 0;
        end
        while (pos < 56) begin
            put_block_byte(pos, 8'h00);
            pos++;
        end
        for (int i = 0; i < 8; i++) put_block_byte(56 + i, len_bits[63 - 8 * i -: 8]);
        fold_block();
        for (int i = 0; i < NUM_H; i++) begin
            r.digest_word = (known == DIG_PREDICTED) ? chain_h[i] : KNOWN_DIGESTS[int'(known)][i];
            r.word_number = 3'(i);
            r.last_word   = (i == NUM_H - 1);
            digest_words_due.push_back(r);
        end
        clear_hash_state();
    endfunction

    // offer one item, with random idle cycles first, and predict it on transfer
    task automatic put_item(input logic [7:0] data, input logic present, input logic eom,
                            input t_known known);
        while ($urandom_range(99) < src_idle_pct) begin
            msg_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        msg_if.valid          <= 1'b1;
        msg_if.data_byte      <= data;
        msg_if.byte_present   <= present;
        msg_if.end_of_message <= eom;
        do @(posedge i_clk); while (!msg_if.ready);
        absorb_item(data, present, eom, known);
        if (present || eom) items_sent++;
    endtask

    // mostly short messages, some around the padding and block edges, a few multi-block
    function automatic int pick_length();
        int roll;
        int edges [8];
        roll  = $urandom_range(99);
        edges = '{55, 56, 57, 63, 64, 65, 119, 120};
        if (roll < 70) return $urandom_range(12);
        if (roll < 90) return edges[$urandom_range(7)];
        return $urandom_range(130, 66);
    endfunction

    task automatic send_message(input int n_bytes);
        for (int i = 0; i < n_bytes; i++) begin
            // stray items with no flags sprinkled in
            if ($urandom_range(9) == 0) put_item(8'($urandom), 1'b0, 1'b0, DIG_PREDICTED);
            put_item(8'($urandom), 1'b1, 1'b0, DIG_PREDICTED);
        end
        put_item(8'($urandom), 1'b0, 1'b1, DIG_PREDICTED);
    endtask

    task automatic send_message_byte_on_final(input int n_bytes);
        for (int i = 0; i < n_bytes - 1; i++) begin
            if ($urandom_range(9) == 0) put_item(8'($urandom), 1'b0, 1'b0, DIG_PREDICTED);
            put_item(8'($urandom), 1'b1, 1'b0, DIG_PREDICTED);
        end
        put_item(8'($urandom), 1'b1, 1'b1, DIG_PREDICTED);
    endtask

    // sender stops until the block has delivered every digest word owed
    task automatic drain();
        msg_if.valid <= 1'b0;
        @(posedge i_clk);
        while (digest_words_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // receiver: check every digest word transfer, then pick next ready
    always @(posedge i_clk) begin : digest_sink
        t_digest_result want;
        int             hold_left;
        bit             hold_served;
        if (i_rst_n && dig_if.valid && dig_if.ready) begin
            if (digest_words_due.size() == 0) begin
                $display("%0t: unexpected digest word, expected none, actual %h",
                         $time, dig_if.digest_word);
                mismatches++;
            end else begin
                want = digest_words_due.pop_front();
                check_field("digest_word", want.digest_word, dig_if.digest_word);
                check_field("word_number", 32'(want.word_number), 32'(dig_if.word_number));
                check_field("last_word", 32'(want.last_word), 32'(dig_if.last_word));
            end
        end
        if (hold_req && !hold_served) begin
            hold_left   = STALL_CYCLES;
            hold_served = 1'b1;
        end
        if (!i_rst_n) begin
            dig_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            dig_if.ready <= 1'b0;
        end else begin
            dig_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin : watchdog
        int quiet;
        if ((msg_if.valid && msg_if.ready) || (dig_if.valid && dig_if.ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCHDOG_MAX) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int phase_items;
        int phase_msgs;
        int len;
        i_rst_n               = 1'b0;
        msg_if.valid          = 1'b0;
        msg_if.data_byte      = 8'h00;
        msg_if.byte_present   = 1'b0;
        msg_if.end_of_message = 1'b0;
        clear_hash_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct = 17;
        sink_idle_pct <= 83;
        for (int r = 0; r < N_DIRECTED; r++) begin
            put_item(DIRECTED[r].data_byte, DIRECTED[r].byte_present,
                     DIRECTED[r].end_of_message, DIRECTED[r].known);
        end

        // three idling phases, each starting from an empty pipeline
        for (int phase = 0; phase < 3; phase++) begin
            drain();
            case (phase)
                0: begin
                    src_idle_pct = 17;
                    sink_idle_pct <= 83;
                end
                1: begin
                    src_idle_pct = 83;
                    sink_idle_pct <= 17;
                end
                default: begin
                    src_idle_pct = 0;
                    sink_idle_pct <= 0;
                    hold_req <= 1'b1;  // receiver holds off while bytes keep coming
                    // short message so a digest is owed well inside the hold-off
                    send_message(3);
                end
            endcase
            phase_items = items_sent;
            phase_msgs  = 0;
            while (items_sent - phase_items < PHASE_ITEMS || phase_msgs < PHASE_MSGS) begin
                len = pick_length();
                if (len > 0 && $urandom_range(1)) send_message_byte_on_final(len);
                else send_message(len);
                phase_msgs++;
            end
        end

        msg_if.valid <= 1'b0;
        while (digest_words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/sha1md_pkg.sv
src/sha1md_intf.sv
src/sha1_message_digest_unit.sv
tb/sha1_message_digest_unit_test.sv
